// File: hw/rtl/dsq_pkg.sv
package dsq_pkg;

  localparam int unsigned FracOne     = 65536;
  localparam int unsigned FracW       = 17;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned KeptW       = 11;
  localparam logic [5:0]  StrideLimit = 6'd63;

  // Request codes
  localparam logic ReqObserve = 1'b0;
  localparam logic ReqQuery   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ValueW-1:0] sample_value;
    logic [FracW-1:0]  quantile_fraction;
  } req_t;

  typedef struct packed {
    logic [ValueW-1:0] quantile_value;
    logic              store_empty;
    logic [KeptW-1:0]  kept_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS_CHECK,
    ST_COMPACT,
    ST_RANK,
    ST_INDEX,
    ST_SCAN,
    ST_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_obs;
    logic take_query;
    logic write_obs;
    logic compact;
    logic compact_finish;
    logic rank;
    logic index;
    logic scan;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic on_stride;
    logic full;
    logic empty;
    logic compact_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/dsq_ram.sv
module dsq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/dsq_ctrl.sv
module dsq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_ready_o,
  input  dsq_pkg::sts_t sts_i,
  output dsq_pkg::cmd_t cmd_o
);

  import dsq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == ReqObserve) begin
            state_d = ST_OBS_CHECK;
          end else if (sts_i.empty) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_RANK;
          end
        end
      end
      ST_OBS_CHECK: begin
        if (!sts_i.on_stride) begin
          state_d = ST_IDLE;
        end else if (sts_i.full) begin
          state_d = ST_COMPACT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_COMPACT: begin
        if (sts_i.compact_done) begin
          state_d = ST_OBS_CHECK;
        end
      end
      ST_RANK:  state_d = ST_INDEX;
      ST_INDEX: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take_obs   = accept && (req_type_i == ReqObserve);
        cmd_o.take_query = accept && (req_type_i == ReqQuery);
      end
      ST_OBS_CHECK: cmd_o.write_obs = sts_i.on_stride && !sts_i.full;
      ST_COMPACT: begin
        cmd_o.compact        = !sts_i.compact_done;
        cmd_o.compact_finish = sts_i.compact_done;
      end
      ST_RANK:   cmd_o.rank     = 1'b1;
      ST_INDEX:  cmd_o.index    = 1'b1;
      ST_SCAN:   cmd_o.scan     = !sts_i.scan_done;
      ST_RESULT: cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // Checks
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.write_obs, cmd_o.compact, cmd_o.compact_finish, cmd_o.scan,
              cmd_o.load_out, cmd_o.rank, cmd_o.index}))
    else $error("more than one datapath command");
  a_compact_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.compact_finish |=> state_q == ST_OBS_CHECK)
    else $error("compaction did not return to stride check");
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE)
    else $error("result load did not end the item");

endmodule

// File: hw/rtl/dsq_dp.sv
module dsq_dp #(
  parameter int unsigned MaxSamples = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsq_pkg::req_t in_data_i,
  input  dsq_pkg::cmd_t cmd_i,
  output dsq_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsq_pkg::rsp_t out_data_o
);

  import dsq_pkg::*;

  localparam int unsigned AW   = $clog2(MaxSamples);
  localparam int unsigned CW   = $clog2(MaxSamples + 1);
  localparam int unsigned PW   = CW + FracW;
  localparam int unsigned Half = (MaxSamples + 1) / 2;

  logic [ValueW-1:0] obs_cnt_q, number_q, value_q;
  logic [5:0]        stride_q;
  logic [CW-1:0]     fill_q;
  logic [FracW-1:0]  frac_q;
  logic [PW-1:0]     prod_q;
  logic [CW-1:0]     k_q, cmatch_q;
  logic [CW-1:0]     cp_cnt_q, sc_cnt_q;
  logic              cp_vld_q, sc_vld_q;
  logic [AW-1:0]     cp_dst_q;
  logic [5:0]        bpos_q;
  logic [ValueW-1:0] mask_q, prefix_q;
  logic              done_q, out_valid_q;
  rsp_t              out_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;
  logic [ValueW-1:0] stride_mask;
  logic [PW-1:0]     rank_sum;
  logic [CW:0]       rank, idx;
  logic [CW:0]       src2;
  logic              cp_issue, sc_issue, bit_end, match;

  dsq_ram #(.Width(ValueW), .Depth(MaxSamples)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Status
  assign stride_mask         = ~({ValueW{1'b1}} << stride_q);
  assign sts_o.on_stride     = (number_q & stride_mask) == '0;
  assign sts_o.full          = fill_q == CW'(MaxSamples);
  assign sts_o.empty         = fill_q == '0;
  assign sts_o.compact_done  = (cp_cnt_q == CW'(Half)) && !cp_vld_q;
  assign sts_o.scan_done     = done_q;
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  // Memory port steering
  assign cp_issue = cmd_i.compact && (cp_cnt_q < CW'(Half));
  assign sc_issue = cmd_i.scan && (sc_cnt_q < fill_q);
  assign bit_end  = cmd_i.scan && (sc_cnt_q == fill_q) && !sc_vld_q;
  assign src2     = {cp_cnt_q, 1'b0};

  always_comb begin
    we    = 1'b0;
    waddr = fill_q[AW-1:0];
    wdata = value_q;
    raddr = sc_cnt_q[AW-1:0];
    if (cmd_i.write_obs) begin
      we = 1'b1;
    end else if (cp_vld_q) begin
      we    = 1'b1;
      waddr = cp_dst_q;
      wdata = rdata;
    end
    if (cmd_i.compact) begin
      raddr = src2[AW-1:0];
    end
  end

  // Rank to index: ceil(f*n/65536) - 1, limited to 0..n-1
  assign rank_sum = prod_q + PW'(FracOne - 1);
  assign rank     = rank_sum[PW-1:16];
  always_comb begin
    idx = (rank == '0) ? '0 : rank - 1'b1;
    if (idx >= {1'b0, fill_q}) begin
      idx = {1'b0, fill_q} - 1'b1;
    end
  end

  // Entry matches the fixed prefix and has a zero at the current bit
  assign match = (((rdata ^ prefix_q) & mask_q) == '0) && !rdata[bpos_q];

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_cnt_q   <= '0;
      stride_q    <= '0;
      fill_q      <= '0;
      cp_cnt_q    <= '0;
      cp_vld_q    <= 1'b0;
      sc_cnt_q    <= '0;
      sc_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_obs) begin
        obs_cnt_q <= obs_cnt_q + 1'b1;
      end
      if (cmd_i.write_obs) begin
        fill_q <= fill_q + 1'b1;
      end
      // compaction: read entry 2i, write it to entry i in the next cycle
      cp_vld_q <= cp_issue;
      if (cp_issue) begin
        cp_cnt_q <= cp_cnt_q + 1'b1;
      end
      if (cmd_i.compact_finish) begin
        fill_q   <= CW'(Half);
        cp_cnt_q <= '0;
        if (stride_q < StrideLimit) begin
          stride_q <= stride_q + 1'b1;
        end
      end
      // bitwise selection scan
      if (cmd_i.take_query) begin
        done_q <= 1'b0;
      end
      if (cmd_i.index) begin
        sc_cnt_q <= '0;
        sc_vld_q <= 1'b0;
      end else begin
        sc_vld_q <= sc_issue;
        if (sc_issue) begin
          sc_cnt_q <= sc_cnt_q + 1'b1;
        end
        if (bit_end) begin
          sc_cnt_q <= '0;
          if (bpos_q == '0) begin
            done_q <= 1'b1;
          end
        end
      end
      // output register
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_obs) begin
      number_q <= obs_cnt_q;
      value_q  <= in_data_i.sample_value;
    end
    if (cmd_i.take_query) begin
      frac_q <= (in_data_i.quantile_fraction > FracW'(FracOne)) ?
                FracW'(FracOne) : in_data_i.quantile_fraction;
    end
    if (cmd_i.compact) begin
      cp_dst_q <= cp_cnt_q[AW-1:0];
    end
    if (cmd_i.rank) begin
      prod_q <= PW'(frac_q) * PW'(fill_q);
    end
    if (cmd_i.index) begin
      k_q      <= idx[CW-1:0];
      bpos_q   <= 6'd63;
      mask_q   <= '0;
      prefix_q <= '0;
      cmatch_q <= '0;
    end else if (bit_end) begin
      if (k_q >= cmatch_q) begin
        k_q              <= k_q - cmatch_q;
        prefix_q[bpos_q] <= 1'b1;
      end
      mask_q[bpos_q] <= 1'b1;
      bpos_q         <= bpos_q - 1'b1;
      cmatch_q       <= '0;
    end else if (sc_vld_q && match) begin
      cmatch_q <= cmatch_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.quantile_value <= (fill_q == '0) ? '0 : prefix_q;
      out_q.store_empty    <= (fill_q == '0);
      out_q.kept_count     <= KeptW'(32'(fill_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MaxSamples))
    else $error("fill count above store size");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_obs |-> fill_q < CW'(MaxSamples))
    else $error("observe write into a full store");
  a_scan_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> k_q < fill_q)
    else $error("selection rank out of range");
  a_compact_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compact_finish |=> fill_q == CW'(Half))
    else $error("compaction left wrong fill");

endmodule

// File: hw/rtl/decimating_sample_quantile_top.sv
// Observe: a sample on the stride is kept; when the store is full it compacts first.
// Query: a 64-pass bitwise selection over the n kept values in the store, one entry
// per cycle through the single RAM read port. An empty-store query skips the scan.
// One item is in work at a time; a result waits in an output register while the next
// item is taken. Reset (async, active low) clears fill, stride and counter; store
// contents are undefined and never read before written.
module decimating_sample_quantile_top #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsq_pkg::rsp_t out_data_o
);

  import dsq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsq_dp #(.MaxSamples(MAX_SAMPLES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/tb_decimating_sample_quantile_top.sv
module tb_decimating_sample_quantile_top;
  import dsq_pkg::*;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned IdleLimit  = 300000;

  // Tracks the decimated store and the results it should produce
  class quantile_scoreboard;
    logic [ValueW-1:0] kept_q[$];
    logic [5:0]        stride_log2;
    logic [63:0]       obs_number;
    rsp_t              expected_q[$];
    int unsigned       errors;
    int unsigned       n_obs, n_query, n_checked;

    function new();
      stride_log2 = '0;
      obs_number  = '0;
      errors      = 0;
      n_obs       = 0;
      n_query     = 0;
      n_checked   = 0;
    endfunction

    function bit on_stride(logic [63:0] num);
      logic [63:0] mask;
      mask = (64'd1 << stride_log2) - 64'd1;
      return (num & mask) == '0;
    endfunction

    function void keep_sample(logic [ValueW-1:0] value);
      logic [63:0]       num;
      logic [ValueW-1:0] even_q[$];
      num        = obs_number;
      obs_number = obs_number + 64'd1;
      if (!on_stride(num)) return;
      if (kept_q.size() >= MaxSamples) begin
        // compact to even positions, then widen the stride
        for (int i = 0; i < kept_q.size(); i += 2) even_q = {even_q, kept_q[i]};
        kept_q = even_q;
        if (stride_log2 < StrideLimit) stride_log2++;
        if (!on_stride(num)) return;
      end
      kept_q = {kept_q, value};
    endfunction

    function rsp_t rank_value(logic [FracW-1:0] frac_in);
      rsp_t              r;
      logic [63:0]       f, rank, idx;
      int unsigned       n;
      logic [ValueW-1:0] sorted[$];
      n = kept_q.size();
      r = '0;
      if (n == 0) begin
        r.store_empty = 1'b1;
        return r;
      end
      f = frac_in;
      if (f > FracOne) f = FracOne;
      rank = (f * n + (FracOne - 1)) >> 16;
      idx  = (rank == 0) ? 64'd0 : rank - 64'd1;
      if (idx > n - 1) idx = n - 1;
      sorted = kept_q;
      sorted.sort();
      r.quantile_value = sorted[idx];
      r.kept_count     = n[KeptW-1:0];
      return r;
    endfunction

    function void note_request(req_t req);
      if (req.req_type == ReqObserve) begin
        n_obs++;
        keep_sample(req.sample_value);
      end else begin
        n_query++;
        expected_q = {expected_q, rank_value(req.quantile_fraction)};
      end
    endfunction

    function void check_result(rsp_t act);
      rsp_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (act.quantile_value !== exp_r.quantile_value) begin
        $display("%0t: quantile_value expected %h actual %h", $time,
                 exp_r.quantile_value, act.quantile_value);
        errors++;
      end
      if (act.store_empty !== exp_r.store_empty) begin
        $display("%0t: store_empty expected %b actual %b", $time,
                 exp_r.store_empty, act.store_empty);
        errors++;
      end
      if (act.kept_count !== exp_r.kept_count) begin
        $display("%0t: kept_count expected %0d actual %0d", $time,
                 exp_r.kept_count, act.kept_count);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  rsp_t  out_data_o;

  quantile_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_count = 0;

  decimating_sample_quantile_top #(.MAX_SAMPLES(MaxSamples)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor: note transfers on both channels, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver stalls: mode changes every so often
  always @(posedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_count <= $urandom_range(16, 200);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send(req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (in_valid_i && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic observe(logic [ValueW-1:0] value);
    req_t r;
    r.req_type          = ReqObserve;
    r.sample_value      = value;
    r.quantile_fraction = FracW'($urandom_range(0, 131071));
    send(r);
  endtask

  task automatic query(logic [FracW-1:0] frac);
    req_t r;
    r.req_type          = ReqQuery;
    r.sample_value      = {$urandom, $urandom};
    r.quantile_fraction = frac;
    send(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FracW-1:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return FracW'($urandom_range(65537, 131071));
      default: return FracW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 15));
      1: return ~64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, field extremes, clamping of the fraction
    query(17'd0);
    query(17'd65536);
    query(17'h1FFFF);
    observe(64'd0);
    query(17'd32768);
    observe('1);
    observe(64'hAAAA_AAAA_AAAA_AAAA);
    observe(64'h5555_5555_5555_5555);
    observe(64'd7);
    query(17'd0);
    query(17'd1);
    query(17'd16384);
    query(17'd32768);
    query(17'd65535);
    query(17'd65536);
    query(17'd65537);
    query(17'h1FFFF);
    observe(64'd7);
    query(17'd39321);
    drain();

    // Random, small store: queries frequent
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 9) < 3) query(rand_frac());
      else observe(rand_value());
    end

    // Hold off until every result is back
    drain();
    repeat ($urandom_range(1, 20)) @(posedge clk_i);

    // Random, growing store through compaction: queries rare (slow at large fill)
    for (int i = 0; i < 1530; i++) begin
      if ($urandom_range(0, 249) == 0) query(rand_frac());
      else observe(rand_value());
    end
    query(17'd0);
    query(17'd65536);
    query(17'd32768);
    drain();
    repeat (600) @(posedge clk_i);

    $display("Run: %0d observes, %0d queries, %0d results checked; final fill %0d, stride 2^%0d",
             sb.n_obs, sb.n_query, sb.n_checked, sb.kept_q.size(), sb.stride_log2);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
